@@ rtl/vfcm_pkg.sv @@
// Shared types and constants for the voxel face culling mesher.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package vfcm_pkg;

  localparam int IN_DATA_W   = 24;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 56;
  localparam int OUT_USER_W  = 2;
  localparam int CNT_W       = 14;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_SCAN    = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_RESTART,
    OP_SCAN
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] z;
    logic [7:0] kind;
  } cmd_t;

  typedef struct packed {
    logic [16:0] index_base;
    logic [15:0] vertex_base;
    logic [7:0]  face_kind;
    logic [2:0]  face_side;
    logic [3:0]  cell_z;
    logic [3:0]  cell_y;
    logic [3:0]  cell_x;
  } rec_t;

endpackage

`default_nettype wire

@@ rtl/voxel_face_culling_mesher_core.sv @@
// Top level of the voxel face culling mesher: front end, command queue and
// back end. Depends on vfcm_pkg, vfcm_front, vfcm_queue and vfcm_back.
//
// Input stream: tuser carries the action (write cell, restart scan, scan next
// cell); tdata carries the cell coordinates and type code of a write. Writes
// and restarts produce nothing; writes outside the chunk and unknown actions
// are dropped. Each scan transfer visits the next cell in y, z, x order and
// produces one record per exposed side of a solid cell; the final cell adds a
// record marking the end of the scan. tlast marks the final record of a scan.
// The cell memory is single ported: a solid cell takes one centre read and six
// neighbour reads. The output is registered. A two-entry queue lets the front
// end keep taking transfers while the back end works. After reset the back
// end sweeps the whole cell memory (EDGE_CELLS rounded up to a power of two,
// cubed: 4096 cells by default) to air, one cell per cycle, with s_axis_tready
// low. When the receiver stalls, the back end holds at its next record and the
// queue fills before the input stalls in turn.
`default_nettype none

module voxel_face_culling_mesher_core #(
  parameter int EDGE_CELLS = 16,
  parameter int KIND_BITS  = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // wr_x[3:0], wr_y[7:4], wr_z[11:8], wr_kind[19:12], zero fill [23:20]
  input  wire logic [vfcm_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // action[1:0]
  input  wire logic [vfcm_pkg::IN_USER_W-1:0]    s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // cell_x[3:0], cell_y[7:4], cell_z[11:8], face_side[14:12], face_kind[22:15],
  // vertex_base[38:23], index_base[55:39]
  output logic [vfcm_pkg::OUT_DATA_W-1:0]        m_axis_tdata_o,
  // is_face[0], scan_done[1]
  output logic [vfcm_pkg::OUT_USER_W-1:0]        m_axis_tuser_o,
  output logic                                   m_axis_tlast_o
);

  vfcm_pkg::cmd_t push_cmd;
  vfcm_pkg::cmd_t head_cmd;
  logic           push;
  logic           queue_full;
  logic           queue_valid;
  logic           pop;
  logic           init_done;

  vfcm_front #(
    .EDGE_CELLS (EDGE_CELLS)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .init_done_i     (init_done),
    .queue_full_i    (queue_full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  vfcm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .pop_i   (pop),
    .cmd_o   (head_cmd)
  );

  vfcm_back #(
    .EDGE_CELLS (EDGE_CELLS),
    .KIND_BITS  (KIND_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (queue_valid),
    .cmd_i           (head_cmd),
    .cmd_pop_o       (pop),
    .init_done_o     (init_done),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

@@ rtl/vfcm_front.sv @@
// Front end: accepts input transfers, decodes the action and drops items
// that have no effect. Depends on vfcm_pkg.
`default_nettype none

module vfcm_front #(
  parameter int EDGE_CELLS = 16
) (
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  input  wire logic [vfcm_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  input  wire logic [vfcm_pkg::IN_USER_W-1:0]      s_axis_tuser_i,
  input  wire logic                                init_done_i,
  input  wire logic                                queue_full_i,
  output logic                                     push_o,
  output vfcm_pkg::cmd_t                           cmd_o
);

  logic [3:0] wr_x;
  logic [3:0] wr_y;
  logic [3:0] wr_z;
  logic       in_range;
  logic       keep;

  assign wr_x = s_axis_tdata_i[3:0];
  assign wr_y = s_axis_tdata_i[7:4];
  assign wr_z = s_axis_tdata_i[11:8];

  assign in_range = (32'(wr_x) < EDGE_CELLS) && (32'(wr_y) < EDGE_CELLS) &&
                    (32'(wr_z) < EDGE_CELLS);

  always_comb begin
    cmd_o.x    = wr_x;
    cmd_o.y    = wr_y;
    cmd_o.z    = wr_z;
    cmd_o.kind = s_axis_tdata_i[19:12];
    cmd_o.op   = vfcm_pkg::OP_SCAN;
    keep       = 1'b0;
    case (vfcm_pkg::action_e'(s_axis_tuser_i))
      vfcm_pkg::ACT_WRITE: begin
        cmd_o.op = vfcm_pkg::OP_WRITE;
        keep     = in_range;
      end
      vfcm_pkg::ACT_RESTART: begin
        cmd_o.op = vfcm_pkg::OP_RESTART;
        keep     = 1'b1;
      end
      vfcm_pkg::ACT_SCAN: begin
        cmd_o.op = vfcm_pkg::OP_SCAN;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign s_axis_tready_o = init_done_i && !queue_full_i;
  assign push_o          = s_axis_tvalid_i && s_axis_tready_o && keep;

endmodule

`default_nettype wire

@@ rtl/vfcm_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on vfcm_pkg for the command type and depth.
`default_nettype none

module vfcm_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire vfcm_pkg::cmd_t  cmd_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  wire logic            pop_i,
  output vfcm_pkg::cmd_t       cmd_o
);

  localparam int PW = $clog2(vfcm_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(vfcm_pkg::QUEUE_DEPTH + 1);

  vfcm_pkg::cmd_t entry_q [vfcm_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q;
  logic [PW-1:0]  rd_ptr_q;
  logic [CW-1:0]  count_q;
  logic           do_push;
  logic           do_pop;

  assign full_o  = (count_q == CW'(vfcm_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(vfcm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(vfcm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/vfcm_back.sv @@
// Back end: owns the cell memory, its clearing pass, the scan position and
// face counter, and the output register. Depends on vfcm_pkg.
`default_nettype none

module vfcm_back #(
  parameter int EDGE_CELLS = 16,
  parameter int KIND_BITS  = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cmd_valid_i,
  input  wire vfcm_pkg::cmd_t                    cmd_i,
  output logic                                   cmd_pop_o,
  output logic                                   init_done_o,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output logic [vfcm_pkg::OUT_DATA_W-1:0]        m_axis_tdata_o,
  output logic [vfcm_pkg::OUT_USER_W-1:0]        m_axis_tuser_o,
  output logic                                   m_axis_tlast_o
);

  localparam int CW    = (EDGE_CELLS > 2) ? $clog2(EDGE_CELLS) : 1;
  localparam int AW    = 3 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int NW    = vfcm_pkg::CNT_W;
  localparam logic [CW-1:0] TOP = CW'(EDGE_CELLS - 1);

  localparam logic [2:0] SIDE_XP = 3'd0;
  localparam logic [2:0] SIDE_XM = 3'd1;
  localparam logic [2:0] SIDE_YP = 3'd2;
  localparam logic [2:0] SIDE_YM = 3'd3;
  localparam logic [2:0] SIDE_ZP = 3'd4;
  localparam logic [2:0] SIDE_ZM = 3'd5;

  localparam logic [2:0] RD_CENTER = 3'd0;
  localparam logic [2:0] RD_LAST   = 3'd6;
  localparam logic [2:0] RD_END    = 3'd7;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  logic [KIND_BITS-1:0] mem [DEPTH];
  logic [KIND_BITS-1:0] mem_rdata_q;
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        mem_addr;
  logic [KIND_BITS-1:0] mem_wdata;

  state_e               state_q;
  logic [AW-1:0]        clr_addr_q;
  logic [CW-1:0]        sx_q;
  logic [CW-1:0]        sy_q;
  logic [CW-1:0]        sz_q;
  logic                 fin_q;
  logic [NW-1:0]        face_ctr_q;
  logic [2:0]           rd_idx_q;
  logic                 chk_vld_q;
  logic [2:0]           chk_idx_q;
  logic [KIND_BITS-1:0] kind_q;
  logic                 pend_vld_q;
  logic [2:0]           pend_side_q;
  logic [NW-1:0]        pend_base_q;
  logic                 out_vld_q;
  vfcm_pkg::rec_t       out_data_q;
  logic                 out_face_q;
  logic                 out_done_q;
  logic                 out_last_q;

  logic [CW-1:0]        nx;
  logic [CW-1:0]        ny;
  logic [CW-1:0]        nz;
  logic [2:0]           rd_side;
  logic [2:0]           chk_side;
  logic                 bnd;
  logic                 rd_zero;
  logic                 exposed;
  logic                 out_free;
  logic                 stall;
  logic                 out_load;
  logic                 last_cell;
  logic [3:0]           cx;
  logic [3:0]           cy;
  logic [3:0]           cz;
  vfcm_pkg::rec_t       pend_rec;
  vfcm_pkg::rec_t       done_rec;

  function automatic vfcm_pkg::rec_t make_rec(input logic [3:0] x, input logic [3:0] y,
                                              input logic [3:0] z, input logic [2:0] side,
                                              input logic [7:0] kind,
                                              input logic [NW-1:0] cnt);
    vfcm_pkg::rec_t r;
    r.cell_x      = x;
    r.cell_y      = y;
    r.cell_z      = z;
    r.face_side   = side;
    r.face_kind   = kind;
    r.vertex_base = {cnt, 2'b00};
    r.index_base  = {1'b0, cnt, 2'b00} + {2'b00, cnt, 1'b0};
    return r;
  endfunction

  assign last_cell = (sx_q == TOP) && (sy_q == TOP) && (sz_q == TOP);
  assign cx        = 4'(sx_q);
  assign cy        = 4'(sy_q);
  assign cz        = 4'(sz_q);
  assign pend_rec  = make_rec(cx, cy, cz, pend_side_q, 8'(kind_q), pend_base_q);
  assign done_rec  = make_rec(cx, cy, cz, SIDE_XP, 8'h00, face_ctr_q);

  assign rd_side  = rd_idx_q - 3'd1;
  assign chk_side = chk_idx_q - 3'd1;
  assign rd_zero  = (mem_rdata_q == '0);
  assign out_free = !out_vld_q || m_axis_tready_i;

  always_comb begin
    case (chk_side)
      SIDE_XP: bnd = (sx_q == TOP);
      SIDE_XM: bnd = (sx_q == '0);
      SIDE_YP: bnd = (sy_q == TOP);
      SIDE_YM: bnd = (sy_q == '0);
      SIDE_ZP: bnd = (sz_q == TOP);
      default: bnd = (sz_q == '0);
    endcase
  end

  assign exposed  = (state_q == ST_SCAN) && chk_vld_q && (chk_idx_q != RD_CENTER) &&
                    (bnd || rd_zero);
  assign stall    = exposed && pend_vld_q && !out_free;
  assign out_load = ((state_q == ST_SCAN) && !stall && exposed && pend_vld_q) ||
                    ((state_q == ST_FLUSH) && out_free && (pend_vld_q || last_cell));

  always_comb begin
    nx = sx_q;
    ny = sy_q;
    nz = sz_q;
    if (rd_idx_q != RD_CENTER) begin
      case (rd_side)
        SIDE_XP: nx = sx_q + CW'(1);
        SIDE_XM: nx = sx_q - CW'(1);
        SIDE_YP: ny = sy_q + CW'(1);
        SIDE_YM: ny = sy_q - CW'(1);
        SIDE_ZP: nz = sz_q + CW'(1);
        default: nz = sz_q - CW'(1);
      endcase
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = {ny, nz, nx};
    mem_wdata = '0;
    cmd_pop_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr_q;
      end
      ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        if (cmd_valid_i && cmd_i.op == vfcm_pkg::OP_WRITE) begin
          mem_we    = 1'b1;
          mem_addr  = {CW'(cmd_i.y), CW'(cmd_i.z), CW'(cmd_i.x)};
          mem_wdata = KIND_BITS'(cmd_i.kind);
        end
      end
      ST_SCAN: begin
        mem_re = !stall && (rd_idx_q != RD_END);
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      sz_q        <= '0;
      fin_q       <= 1'b0;
      face_ctr_q  <= '0;
      rd_idx_q    <= RD_CENTER;
      chk_vld_q   <= 1'b0;
      chk_idx_q   <= RD_CENTER;
      kind_q      <= '0;
      pend_vld_q  <= 1'b0;
      pend_side_q <= SIDE_XP;
      pend_base_q <= '0;
      out_vld_q   <= 1'b0;
      out_data_q  <= '0;
      out_face_q  <= 1'b0;
      out_done_q  <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (m_axis_tready_i && !out_load) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + AW'(1);
          if (clr_addr_q == AW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_i.op)
              vfcm_pkg::OP_RESTART: begin
                sx_q       <= '0;
                sy_q       <= '0;
                sz_q       <= '0;
                fin_q      <= 1'b0;
                face_ctr_q <= '0;
              end
              vfcm_pkg::OP_SCAN: begin
                if (!fin_q) begin
                  state_q   <= ST_SCAN;
                  rd_idx_q  <= RD_CENTER;
                  chk_vld_q <= 1'b0;
                end
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (!stall) begin
            if (rd_idx_q != RD_END) begin
              rd_idx_q  <= rd_idx_q + 3'd1;
              chk_vld_q <= 1'b1;
              chk_idx_q <= rd_idx_q;
            end else begin
              chk_vld_q <= 1'b0;
            end
            if (chk_vld_q) begin
              if (chk_idx_q == RD_CENTER) begin
                kind_q <= mem_rdata_q;
                if (rd_zero) begin
                  state_q <= ST_FLUSH;
                end
              end else begin
                if (exposed) begin
                  if (pend_vld_q) begin
                    out_vld_q  <= 1'b1;
                    out_data_q <= pend_rec;
                    out_face_q <= 1'b1;
                    out_done_q <= last_cell;
                    out_last_q <= 1'b0;
                  end
                  pend_vld_q  <= 1'b1;
                  pend_side_q <= chk_side;
                  pend_base_q <= face_ctr_q;
                  face_ctr_q  <= face_ctr_q + NW'(1);
                end
                if (chk_idx_q == RD_LAST) begin
                  state_q <= ST_FLUSH;
                end
              end
            end
          end
        end
        default: begin
          if (out_free) begin
            if (pend_vld_q) begin
              out_vld_q  <= 1'b1;
              out_data_q <= pend_rec;
              out_face_q <= 1'b1;
              out_done_q <= last_cell;
              out_last_q <= !last_cell;
              pend_vld_q <= 1'b0;
            end else if (last_cell) begin
              out_vld_q  <= 1'b1;
              out_data_q <= done_rec;
              out_face_q <= 1'b0;
              out_done_q <= 1'b1;
              out_last_q <= 1'b1;
            end
            if (!pend_vld_q || !last_cell) begin
              state_q <= ST_IDLE;
              if (last_cell) begin
                fin_q <= 1'b1;
              end
              if (sx_q == TOP) begin
                sx_q <= '0;
                if (sz_q == TOP) begin
                  sz_q <= '0;
                  sy_q <= sy_q + CW'(1);
                end else begin
                  sz_q <= sz_q + CW'(1);
                end
              end else begin
                sx_q <= sx_q + CW'(1);
              end
            end
          end
        end
      endcase
    end
  end

  assign init_done_o     = (state_q != ST_CLEAR);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = {out_done_q, out_face_q};
  assign m_axis_tlast_o  = out_last_q;

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_vld_q)
    else $error("pending face left over after a scan finished");

  a_clear_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !cmd_pop_o)
    else $error("command taken during the clearing pass");

  a_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("cell memory written and read in the same cycle");

  a_counter_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    face_ctr_q != $past(face_ctr_q) |->
      (face_ctr_q == NW'($past(face_ctr_q) + 1'b1)) || (face_ctr_q == '0))
    else $error("face counter moved by more than one face");

endmodule

`default_nettype wire
